// ===== design/stp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stp_pkg: shared types and codes for the software timer pool
// Operation, status and event codes, command and result records.
// ----------------------------------------------------------------------------
package stp_pkg;

	localparam int NUM_TIMERS = 32;
	localparam int SLOT_W     = $clog2(NUM_TIMERS);
	localparam int ID_W       = 6;
	localparam int CNT_W      = 32;
	localparam int QCNT_W     = SLOT_W + 1;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_ALLOC  = 3'd1,
		OP_FREE   = 3'd2,
		OP_START  = 3'd3,
		OP_STOP   = 3'd4,
		OP_RECONF = 3'd5,
		OP_QUERY  = 3'd6,
		OP_POP    = 3'd7
	} op_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_BAD_ID  = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	localparam logic [1:0] EV_RESP      = 2'd0;
	localparam logic [1:0] EV_EXPIRE    = 2'd1;
	localparam logic [1:0] EV_POPPED    = 2'd2;
	localparam logic [1:0] EV_TICK_DONE = 2'd3;

	localparam logic [1:0] TS_STOPPED = 2'd0;
	localparam logic [1:0] TS_RUNNING = 2'd1;
	localparam logic [1:0] TS_INVALID = 2'd2;

	localparam logic [1:0] MODE_FREE    = 2'd0;
	localparam logic [1:0] MODE_ONESHOT = 2'd1;
	localparam logic [1:0] MODE_CONT    = 2'd2;

	typedef struct packed {
		op_t               op;
		logic [ID_W-1:0]   id;
		logic              in_range;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  period;
		logic              repeat_mode;
		logic              immediate_notify;
		logic              has_handler;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0] result_id;
		logic [1:0]      status;
		logic [1:0]      timer_state;
		logic [1:0]      event_kind;
		logic [ID_W-1:0] in_use;
		logic [ID_W-1:0] peak_in_use;
		logic            last;
	} result_t;

	typedef enum logic [2:0] {
		S_EXEC,
		S_START,
		S_TICK_RD,
		S_TICK_EX,
		S_TICK_DONE
	} back_state_t;

endpackage
`default_nettype wire

// ===== design/stp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stp_if: request and response channels of the timer pool
// Valid/ready channels; a transfer happens when both are high.
// ----------------------------------------------------------------------------
interface stp_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [5:0]  timer_id;
	logic [31:0] period;
	logic        repeat_mode;
	logic        immediate_notify;
	logic        has_handler;
	modport source (output valid, operation, timer_id, period, repeat_mode,
		immediate_notify, has_handler, input ready);
	modport sink (input valid, operation, timer_id, period, repeat_mode,
		immediate_notify, has_handler, output ready);
endinterface

interface stp_rsp_if;
	logic       valid;
	logic       ready;
	logic [5:0] result_id;
	logic [1:0] status;
	logic [1:0] timer_state;
	logic [1:0] event_kind;
	logic [5:0] in_use;
	logic [5:0] peak_in_use;
	logic       last;
	modport source (output valid, result_id, status, timer_state, event_kind,
		in_use, peak_in_use, last, input ready);
	modport sink (input valid, result_id, status, timer_state, event_kind,
		in_use, peak_in_use, last, output ready);
endinterface
`default_nettype wire

// ===== design/stp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stp_front: request intake
// Decodes the id range and slot, and holds commands in a two-entry queue.
// ----------------------------------------------------------------------------
module stp_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	stp_req_if.sink         req,
	output stp_pkg::cmd_t   cmd,
	output logic            cmd_valid,
	input  wire logic       cmd_pop
);
	stp_pkg::cmd_t cmd_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	stp_pkg::cmd_t new_cmd;
	logic          push;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = cmd_q[rd_ptr_q];

	always_comb begin
		new_cmd.op               = stp_pkg::op_t'(req.operation);
		new_cmd.id               = req.timer_id;
		new_cmd.in_range         = (req.timer_id >= stp_pkg::ID_W'(1)) &&
			(req.timer_id <= stp_pkg::ID_W'(stp_pkg::NUM_TIMERS));
		new_cmd.slot             = new_cmd.in_range ?
			stp_pkg::SLOT_W'(req.timer_id - stp_pkg::ID_W'(1)) : '0;
		new_cmd.period           = req.period[stp_pkg::CNT_W-1:0];
		new_cmd.repeat_mode      = req.repeat_mode;
		new_cmd.immediate_notify = req.immediate_notify;
		new_cmd.has_handler      = req.has_handler;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule
`default_nettype wire

// ===== design/stp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stp_back: timer table and command execution
// Runs commands against the slot table, walks slots on a tick, keeps the
// expiry queue and drives the response register.
// ----------------------------------------------------------------------------
module stp_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire stp_pkg::cmd_t cmd,
	input  wire logic       cmd_valid,
	output logic            cmd_pop,
	stp_rsp_if.source       rsp
);
	localparam int N  = stp_pkg::NUM_TIMERS;
	localparam int SW = stp_pkg::SLOT_W;
	localparam int IW = stp_pkg::ID_W;
	localparam int CW = stp_pkg::CNT_W;
	localparam int QW = stp_pkg::QCNT_W;

	logic [CW-1:0] per_mem [N];
	logic [CW-1:0] cnt_mem [N];
	logic [CW-1:0] per_rd_q, cnt_rd_q;
	logic [SW-1:0] rd_idx;
	logic          per_we, cnt_we;
	logic [SW-1:0] per_wa, cnt_wa;
	logic [CW-1:0] per_wd, cnt_wd;

	logic [1:0]    mode_q [N];
	logic [1:0]    mode_d [N];
	logic [N-1:0]  imm_q, imm_d, hnd_q, hnd_d, run_q, run_d, pend_q, pend_d;
	logic [IW-1:0] pq_q [N];
	logic [IW-1:0] pq_d [N];
	logic [QW-1:0] pq_cnt_q, pq_cnt_d;
	logic [IW-1:0] use_q, use_d, peak_q, peak_d;
	logic [SW-1:0] tick_i_q, tick_i_d;
	stp_pkg::back_state_t st_q, st_d;
	logic             ovld_q, ovld_d;
	stp_pkg::result_t ores_q, ores_d;

	logic          out_free, emit, free_any, cmd_ok;
	logic [SW-1:0] free_idx;
	logic [CW-1:0] norm_per;
	logic [IW-1:0] cx_id;
	logic [N-1:0]  cx_mask, cx_pre;
	logic [IW-1:0] cx_q [N];
	logic          cx_hit;
	logic [SW-1:0] j;
	logic          act, expire, emit_exp;

	assign out_free        = !ovld_q || rsp.ready;
	assign rsp.valid       = ovld_q;
	assign rsp.result_id   = ores_q.result_id;
	assign rsp.status      = ores_q.status;
	assign rsp.timer_state = ores_q.timer_state;
	assign rsp.event_kind  = ores_q.event_kind;
	assign rsp.in_use      = ores_q.in_use;
	assign rsp.peak_in_use = ores_q.peak_in_use;
	assign rsp.last        = ores_q.last;

	assign norm_per = (cmd.period == '0) ? CW'(1) : cmd.period;
	assign cmd_ok   = cmd.in_range && (mode_q[cmd.slot] != stp_pkg::MODE_FREE);
	assign rd_idx   = (st_q == stp_pkg::S_TICK_RD || st_q == stp_pkg::S_TICK_EX)
		? tick_i_q : cmd.slot;
	assign j        = tick_i_q;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int k = N - 1; k >= 0; k--) begin
			if (mode_q[k] == stp_pkg::MODE_FREE) begin
				free_any = 1'b1;
				free_idx = SW'(k);
			end
		end
	end

	// cancel: drop the matching queue entry and close the gap
	always_comb begin
		cx_id = IW'(cmd.slot) + IW'(1);
		for (int k = 0; k < N; k++) begin
			cx_mask[k] = (pq_q[k] == cx_id) && (QW'(k) < pq_cnt_q);
		end
		cx_pre[0] = cx_mask[0];
		for (int k = 1; k < N; k++) cx_pre[k] = cx_pre[k-1] | cx_mask[k];
		for (int k = 0; k < N; k++) begin
			if (cx_pre[k] && k < N - 1) cx_q[k] = pq_q[(k < N - 1) ? k + 1 : k];
			else cx_q[k] = pq_q[k];
		end
		cx_hit = cx_pre[N-1];
	end

	always_comb begin
		mode_d   = mode_q;
		imm_d    = imm_q;
		hnd_d    = hnd_q;
		run_d    = run_q;
		pend_d   = pend_q;
		pq_d     = pq_q;
		pq_cnt_d = pq_cnt_q;
		use_d    = use_q;
		peak_d   = peak_q;
		tick_i_d = tick_i_q;
		st_d     = st_q;
		cmd_pop  = 1'b0;
		emit     = 1'b0;
		per_we   = 1'b0;
		per_wa   = cmd.slot;
		per_wd   = norm_per;
		cnt_we   = 1'b0;
		cnt_wa   = cmd.slot;
		cnt_wd   = per_rd_q;
		ores_d   = ores_q;
		ores_d.timer_state = stp_pkg::TS_STOPPED;
		ores_d.event_kind  = stp_pkg::EV_RESP;
		ores_d.status      = stp_pkg::ST_OK;
		ores_d.last        = 1'b1;
		ores_d.result_id   = cmd.id;
		act      = (mode_q[j] != stp_pkg::MODE_FREE) && run_q[j];
		expire   = act && (cnt_rd_q == '0);
		emit_exp = expire && hnd_q[j] && imm_q[j];

		unique case (st_q)
			stp_pkg::S_EXEC: begin
				if (cmd_valid && cmd.op == stp_pkg::OP_TICK) begin
					tick_i_d = '0;
					st_d     = stp_pkg::S_TICK_RD;
				end else if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					emit    = 1'b1;
					unique case (cmd.op)
						stp_pkg::OP_ALLOC: begin
							if (free_any) begin
								per_we = 1'b1;
								per_wa = free_idx;
								cnt_we = 1'b1;
								cnt_wa = free_idx;
								cnt_wd = norm_per - CW'(1);
								mode_d[free_idx] = cmd.repeat_mode ?
									stp_pkg::MODE_CONT : stp_pkg::MODE_ONESHOT;
								imm_d[free_idx]  = cmd.immediate_notify;
								hnd_d[free_idx]  = cmd.has_handler;
								run_d[free_idx]  = 1'b0;
								pend_d[free_idx] = 1'b0;
								use_d = use_q + IW'(1);
								if (use_d > peak_q) peak_d = use_d;
								ores_d.result_id = IW'(free_idx) + IW'(1);
							end else begin
								ores_d.result_id = '0;
								ores_d.status    = stp_pkg::ST_NO_FREE;
							end
						end
						stp_pkg::OP_QUERY: begin
							if (!cmd.in_range) begin
								ores_d.result_id   = '0;
								ores_d.status      = stp_pkg::ST_BAD_ID;
								ores_d.timer_state = stp_pkg::TS_INVALID;
							end else if (!cmd_ok) begin
								ores_d.timer_state = stp_pkg::TS_INVALID;
							end else begin
								ores_d.timer_state = run_q[cmd.slot] ?
									stp_pkg::TS_RUNNING : stp_pkg::TS_STOPPED;
							end
						end
						stp_pkg::OP_POP: begin
							if (pq_cnt_q == '0) begin
								ores_d.result_id = '0;
								ores_d.status    = stp_pkg::ST_EMPTY;
							end else begin
								ores_d.result_id  = pq_q[0];
								ores_d.event_kind = stp_pkg::EV_POPPED;
								pend_d[SW'(pq_q[0] - IW'(1))] = 1'b0;
								for (int k = 0; k < N - 1; k++) pq_d[k] = pq_q[k+1];
								pq_cnt_d = pq_cnt_q - QW'(1);
							end
						end
						default: begin
							if (!cmd_ok) begin
								ores_d.result_id = '0;
								ores_d.status    = stp_pkg::ST_BAD_ID;
							end else if (cmd.op == stp_pkg::OP_START) begin
								cmd_pop = 1'b0;
								emit    = 1'b0;
								st_d    = stp_pkg::S_START;
							end else begin
								run_d[cmd.slot] = 1'b0;
								if (pend_q[cmd.slot]) begin
									pend_d[cmd.slot] = 1'b0;
									if (cx_hit) begin
										pq_d     = cx_q;
										pq_cnt_d = pq_cnt_q - QW'(1);
									end
								end
								if (cmd.op == stp_pkg::OP_FREE) begin
									mode_d[cmd.slot] = stp_pkg::MODE_FREE;
									if (use_q != '0) use_d = use_q - IW'(1);
								end else if (cmd.op == stp_pkg::OP_RECONF) begin
									per_we = 1'b1;
									hnd_d[cmd.slot] = cmd.has_handler;
								end
							end
						end
					endcase
				end
			end
			stp_pkg::S_START: begin
				if (out_free) begin
					cnt_we  = 1'b1;
					run_d[cmd.slot] = 1'b1;
					emit    = 1'b1;
					cmd_pop = 1'b1;
					st_d    = stp_pkg::S_EXEC;
				end
			end
			stp_pkg::S_TICK_RD: begin
				st_d = stp_pkg::S_TICK_EX;
			end
			stp_pkg::S_TICK_EX: begin
				if (!emit_exp || out_free) begin
					cnt_wa = j;
					if (expire) begin
						if (mode_q[j] == stp_pkg::MODE_CONT) begin
							cnt_we = 1'b1;
							cnt_wd = per_rd_q - CW'(1);
						end else begin
							run_d[j] = 1'b0;
						end
						if (hnd_q[j] && !imm_q[j] && !pend_q[j]) begin
							pq_d[pq_cnt_q[SW-1:0]] = IW'(j) + IW'(1);
							pq_cnt_d  = pq_cnt_q + QW'(1);
							pend_d[j] = 1'b1;
						end
					end else if (act) begin
						cnt_we = 1'b1;
						cnt_wd = cnt_rd_q - CW'(1);
					end
					if (emit_exp) begin
						emit = 1'b1;
						ores_d.result_id  = IW'(j) + IW'(1);
						ores_d.event_kind = stp_pkg::EV_EXPIRE;
						ores_d.last       = 1'b0;
					end
					if (j == SW'(N - 1)) begin
						st_d = stp_pkg::S_TICK_DONE;
					end else begin
						tick_i_d = j + SW'(1);
						st_d     = stp_pkg::S_TICK_RD;
					end
				end
			end
			stp_pkg::S_TICK_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					cmd_pop = 1'b1;
					ores_d.result_id  = '0;
					ores_d.event_kind = stp_pkg::EV_TICK_DONE;
					st_d = stp_pkg::S_EXEC;
				end
			end
			default: st_d = stp_pkg::S_EXEC;
		endcase

		ores_d.in_use      = use_d;
		ores_d.peak_in_use = peak_d;
		if (!emit) ores_d = ores_q;
		ovld_d = emit ? 1'b1 : (rsp.ready ? 1'b0 : ovld_q);
	end

	always_ff @(posedge clk) begin
		if (per_we) per_mem[per_wa] <= per_wd;
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		per_rd_q <= per_mem[rd_idx];
		cnt_rd_q <= cnt_mem[rd_idx];
		pq_q     <= pq_d;
		ores_q   <= ores_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) mode_q[k] <= stp_pkg::MODE_FREE;
			imm_q    <= '0;
			hnd_q    <= '0;
			run_q    <= '0;
			pend_q   <= '0;
			pq_cnt_q <= '0;
			use_q    <= '0;
			peak_q   <= '0;
			tick_i_q <= '0;
			st_q     <= stp_pkg::S_EXEC;
			ovld_q   <= 1'b0;
		end else begin
			mode_q   <= mode_d;
			imm_q    <= imm_d;
			hnd_q    <= hnd_d;
			run_q    <= run_d;
			pend_q   <= pend_d;
			pq_cnt_q <= pq_cnt_d;
			use_q    <= use_d;
			peak_q   <= peak_d;
			tick_i_q <= tick_i_d;
			st_q     <= st_d;
			ovld_q   <= ovld_d;
		end
	end
endmodule
`default_nettype wire

// ===== design/software_timer_pool.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_pool: pool of 32 countdown timers
// A tick walks all 32 slots, reading each from the count/period memory and
// then updating it, and can wait on the response side; start passes through
// S_START; other non-tick operations answer in S_EXEC. Immediate expiries
// come out in slot order before the tick-done response. A two-entry command
// queue takes new requests while the table is busy.
// ----------------------------------------------------------------------------
module software_timer_pool (
	input  wire logic clk,
	input  wire logic arst_n,
	stp_req_if.sink   req,
	stp_rsp_if.source rsp
);
	stp_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_pop;

	stp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	stp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire

// ===== design/stp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stp_checker: port-level checks for the timer pool
// Watches the response channel and the counts it reports.
// ----------------------------------------------------------------------------
module stp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [5:0] rsp_result_id,
	input wire logic [1:0] rsp_status,
	input wire logic [1:0] rsp_event_kind,
	input wire logic [5:0] rsp_in_use,
	input wire logic [5:0] rsp_peak_in_use,
	input wire logic       rsp_last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before transfer");

	a_tick_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_event_kind == stp_pkg::EV_TICK_DONE |->
		rsp_last && rsp_result_id == 6'd0)
		else $error("tick done malformed");

	a_expire: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_event_kind == stp_pkg::EV_EXPIRE |->
		!rsp_last && rsp_result_id != 6'd0)
		else $error("expiry malformed");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_peak_in_use >= rsp_in_use)
		else $error("peak below in use");

	a_err_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == stp_pkg::ST_NO_FREE ||
		rsp_status == stp_pkg::ST_BAD_ID) |-> rsp_result_id == 6'd0)
		else $error("error response carries id");
endmodule

bind software_timer_pool stp_checker u_stp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_result_id   (rsp.result_id),
	.rsp_status      (rsp.status),
	.rsp_event_kind  (rsp.event_kind),
	.rsp_in_use      (rsp.in_use),
	.rsp_peak_in_use (rsp.peak_in_use),
	.rsp_last        (rsp.last)
);
`default_nettype wire
